// ----- rtl/core/pqrp_pkg.sv -----
// Package with constants, codes and types shared by the palette quantize and pack block.
`timescale 1ns / 1ps
`default_nettype none
package pqrp_pkg;

  localparam int PANEL_WIDTH  = 122;
  localparam int PANEL_HEIGHT = 250;
  localparam int ROW_STRIDE   = 32;
  localparam int STORE_BYTES  = PANEL_HEIGHT * ROW_STRIDE;
  localparam int STORE_AW     = $clog2(STORE_BYTES);

  localparam logic [7:0] FILL_WHITE = 8'h55;

  localparam logic [1:0] KIND_FILL  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] CFG_BLACK  = 2'd0;
  localparam logic [1:0] CFG_WHITE  = 2'd1;
  localparam logic [1:0] CFG_YELLOW = 2'd2;
  localparam logic [1:0] CFG_RED    = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  land_x;
    logic [6:0]  land_y;
    logic [15:0] rgb;
    logic [12:0] read_addr;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       pixel_dropped;
    logic [1:0] color_code;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic fill_wr;
    logic merge_wr;
    logic fill_step;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       wr_ok;
    logic       rd_ok;
    logic       fill_last;
  } stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/palette_quantize_rotate_pack_unit.sv -----
// Top level of the palette quantize, rotate and pack frame store block.
// Steps: a pixel passes IDLE, MERGE and PUSH; a dropped pixel, read or unknown kind IDLE and PUSH.
// A new item is taken only after the last one's result is pushed; PUSH waits while a result is held.
// A start frame walks the frame store one byte per cycle, 8000 bytes at the default size.
// The result register lets the next transaction be accepted while a result waits.
// Reset clears control state and restores the palette codes; the store is undefined until filled.
`timescale 1ns / 1ps
`default_nettype none
module palette_quantize_rotate_pack_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire pqrp_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output pqrp_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [1:0]          cfg_data_i
);
  import pqrp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pqrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pqrp_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .out_data_o(out_data_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd),
    .stat_o    (stat)
  );

endmodule
`default_nettype wire

// ----- rtl/core/pqrp_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pqrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/pqrp_ctrl.sv -----
// Controller state machine that sequences fill, read-modify-write, read and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module pqrp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire pqrp_pkg::stat_t stat_i,
  output pqrp_pkg::cmd_t      cmd_o
);
  import pqrp_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FILL  = 2'd1;
  localparam logic [1:0] S_MERGE = 2'd2;
  localparam logic [1:0] S_PUSH  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (stat_i.kind)
            KIND_FILL: begin
              state_d = S_FILL;
            end
            KIND_PIXEL: begin
              if (stat_i.wr_ok) begin
                cmd_o.rd_en = 1'b1;
                state_d     = S_MERGE;
              end else begin
                state_d = S_PUSH;
              end
            end
            KIND_READ: begin
              cmd_o.rd_en = stat_i.rd_ok;
              state_d     = S_PUSH;
            end
            default: begin
              state_d = S_PUSH;
            end
          endcase
        end
      end
      S_FILL: begin
        cmd_o.fill_wr   = 1'b1;
        cmd_o.fill_step = 1'b1;
        if (stat_i.fill_last) begin
          state_d = S_PUSH;
        end
      end
      S_MERGE: begin
        cmd_o.merge_wr = 1'b1;
        state_d        = S_PUSH;
      end
      S_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pqrp_dp.sv -----
// Datapath with palette match, rotation, byte merge, fill counter, frame store and result register.
`timescale 1ns / 1ps
`default_nettype none
module pqrp_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pqrp_pkg::in_item_t in_data_i,
  output pqrp_pkg::out_item_t     out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [1:0]         cfg_data_i,
  input  wire pqrp_pkg::cmd_t     cmd_i,
  output pqrp_pkg::stat_t         stat_o
);
  import pqrp_pkg::*;

  in_item_t            in_q, cur;
  out_item_t           out_q;
  logic [1:0]          black_q, white_q, yellow_q, red_q;
  logic [STORE_AW-1:0] fill_cnt_q;

  logic [7:0]          r8, g8, b8;
  logic [9:0]          sum_rgb;
  logic [8:0]          sum_rg;
  logic signed [11:0]  d_white, d_yel, d_red, best;
  logic [1:0]          code;
  logic                drop;
  logic [8:0]          row;
  logic [15:0]         idx;
  logic                wr_ok, rd_ok;
  logic [2:0]          sh;
  logic [7:0]          mask, merged, rdata;
  logic                ram_we;
  logic [STORE_AW-1:0] waddr, raddr;
  logic [7:0]          wdata;

  assign cur = cmd_i.load ? in_data_i : in_q;

  assign r8 = {cur.rgb[15:11], 3'b000};
  assign g8 = {cur.rgb[10:5], 2'b00};
  assign b8 = {cur.rgb[4:0], 3'b000};

  // Distances relative to black, scaled down by 255; order and ties are preserved.
  assign sum_rgb  = {2'b00, r8} + {2'b00, g8} + {2'b00, b8};
  assign sum_rg   = {1'b0, r8} + {1'b0, g8};
  assign d_white  = 12'sd765 - $signed({1'b0, sum_rgb, 1'b0});
  assign d_yel    = 12'sd510 - $signed({2'b00, sum_rg, 1'b0});
  assign d_red    = 12'sd255 - $signed({3'b000, r8, 1'b0});

  always_comb begin
    best = 12'sd0;
    code = black_q;
    if (d_white < best) begin
      best = d_white;
      code = white_q;
    end
    if (d_yel < best) begin
      best = d_yel;
      code = yellow_q;
    end
    if (d_red < best) begin
      code = red_q;
    end
  end

  assign drop = ({1'b0, cur.land_y} >= 8'(PANEL_WIDTH)) ||
                ({1'b0, cur.land_x} >= 9'(PANEL_HEIGHT)) ||
                ({1'b0, cur.land_y[6:2]} >= 6'(ROW_STRIDE));
  assign row   = 9'(PANEL_HEIGHT - 1) - {1'b0, cur.land_x};
  assign idx   = 16'(row) * 16'(ROW_STRIDE) + 16'(cur.land_y[6:2]);
  assign wr_ok = !drop && (idx < 16'(STORE_BYTES));
  assign rd_ok = {1'b0, cur.read_addr} < 14'(STORE_BYTES);

  assign sh     = {~cur.land_y[1:0], 1'b0};
  assign mask   = 8'h03 << sh;
  assign merged = (rdata & ~mask) | ({6'b0, code} << sh);

  assign ram_we = cmd_i.fill_wr || cmd_i.merge_wr;
  assign waddr  = cmd_i.fill_wr ? fill_cnt_q : idx[STORE_AW-1:0];
  assign wdata  = cmd_i.fill_wr ? FILL_WHITE : merged;
  assign raddr  = (cur.kind == KIND_READ) ? cur.read_addr[STORE_AW-1:0] : idx[STORE_AW-1:0];

  pqrp_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign stat_o.kind      = cur.kind;
  assign stat_o.wr_ok     = wr_ok;
  assign stat_o.rd_ok     = rd_ok;
  assign stat_o.fill_last = (fill_cnt_q == STORE_AW'(STORE_BYTES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q  <= 2'd0;
      white_q  <= 2'd1;
      yellow_q <= 2'd2;
      red_q    <= 2'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLACK:  black_q  <= cfg_data_i;
        CFG_WHITE:  white_q  <= cfg_data_i;
        CFG_YELLOW: yellow_q <= cfg_data_i;
        CFG_RED:    red_q    <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q <= '0;
    end else if (cmd_i.load) begin
      fill_cnt_q <= '0;
    end else if (cmd_i.fill_step) begin
      fill_cnt_q <= fill_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
    if (cmd_i.push) begin
      out_q.read_data     <= ((in_q.kind == KIND_READ) && rd_ok) ? rdata : 8'h00;
      out_q.pixel_dropped <= (in_q.kind == KIND_PIXEL) && drop;
      out_q.color_code    <= (in_q.kind == KIND_PIXEL) ? code : 2'd0;
    end
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire
